@@ hw/rtl/rgb2ypbpr_pkg.sv @@
// shared types and constants for the rgb to ypbpr converter
package rgb2ypbpr_pkg;

    localparam int N_CH       = 3;
    localparam int COEF_W     = 21;
    localparam int COEF_SCALE = 1000000;
    localparam int OUT_W      = 16;
    localparam int ADDR_W     = 3;

    localparam logic [15:0] RESET_MAX_SAMPLE = 16'd255;

    typedef enum logic [0:0] {
        REG_MAX_SAMPLE = 1'b0
    } t_reg_idx;

    // rows: luma, chroma blue, chroma red; columns: red, green, blue
    localparam logic signed [COEF_W-1:0] C_COEF [N_CH][N_CH] = '{
        '{ 21'sd299000,   21'sd587000,   21'sd114000 },
        '{ -21'sd168736,  -21'sd331264,  21'sd500000 },
        '{ 21'sd500000,   -21'sd418688,  -21'sd81312 }
    };

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic        [15:0] luma;
        logic signed [15:0] chroma_blue;
        logic signed [15:0] chroma_red;
    } t_pix_out;

endpackage

@@ hw/rtl/rgb_to_ypbpr_convert.sv @@
// rgb to ypbpr bt.601 conversion pipeline with apb configuration
// stages: clamp, products, magnitude, numerator, the 16 stage divider, output register
// throughput: one word per cycle while i_stall is low, a stage takes a word when it advances
// stalls back-pressure stage by stage, bubbles are squeezed out
// synchronous active-low reset clears valid bits and sets max_sample to 255
// no clearing pass, the block accepts words in the cycle after reset
module rgb_to_ypbpr_convert
    import rgb2ypbpr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_pix_in           i_pix,
    output logic              o_valid,
    input  logic              i_stall,
    output t_pix_out          o_pix,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int MAG_W  = SB + 20;
    localparam int DEN_W  = SB + 20;
    localparam int NUM_W  = SB + 37;
    localparam int PROD_W = SB + COEF_W + 1;
    localparam int ACC_W  = SB + COEF_W + 3;
    localparam int N_DIV  = OUT_W;
    localparam int ST_NUM = 3;
    localparam int ST_OUT = ST_NUM + N_DIV + 1;
    localparam int N_STG  = ST_OUT + 1;

    function automatic logic [DEN_W-1:0] den_of(input logic [SB-1:0] m);
        logic [DEN_W-1:0] d;
        if (m == '0) begin
            d = DEN_W'(COEF_SCALE);
        end else begin
            d = DEN_W'(m) * DEN_W'(COEF_SCALE);
        end
        return d;
    endfunction

    logic [15:0]       r_max_sample;
    logic [DEN_W-1:0]  r_den;
    logic              w_wr;
    logic [SB-1:0]     w_max;

    logic [N_STG-1:0]  r_vld;
    logic [N_STG-1:0]  w_adv;

    logic [SB-1:0]                w_in   [N_CH];
    logic [SB-1:0]                r_smp  [N_CH];
    logic signed [PROD_W-1:0]     r_prod [N_CH][N_CH];
    logic signed [ACC_W-1:0]      w_acc  [N_CH];
    logic                         r_neg2 [N_CH];
    logic [MAG_W-1:0]             r_mag  [N_CH];
    logic [NUM_W-1:0]             r_rem  [N_DIV+1][N_CH];
    logic [N_DIV-1:0]             r_quo  [N_DIV+1][N_CH];
    logic                         r_neg  [N_DIV+1][N_CH];
    logic [NUM_W-1:0]             w_dvs  [N_DIV];
    t_pix_out                     r_out;
    t_pix_out                     n_out;

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_MAX_SAMPLE);
    assign w_max  = r_max_sample[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sample <= RESET_MAX_SAMPLE;
            r_den        <= den_of(RESET_MAX_SAMPLE[SB-1:0]);
        end else if (w_wr) begin
            r_max_sample <= pwdata[15:0];
            r_den        <= den_of(pwdata[SB-1:0]);
        end
    end

    always_comb begin
        if (paddr[2] == REG_MAX_SAMPLE) begin
            prdata = {16'b0, r_max_sample};
        end else begin
            prdata = '0;
        end
    end

    // stage advance chain
    always_comb begin
        w_adv[N_STG-1] = !r_vld[N_STG-1] || !i_stall;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[ST_OUT];
    assign o_pix   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // clamp
    assign w_in[0] = i_pix.red_in[SB-1:0];
    assign w_in[1] = i_pix.green_in[SB-1:0];
    assign w_in[2] = i_pix.blue_in[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            for (int c = 0; c < N_CH; c++) begin
                r_smp[c] <= (w_in[c] > w_max) ? w_max : w_in[c];
            end
        end
    end

    // matrix products
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int k = 0; k < N_CH; k++) begin
                for (int c = 0; c < N_CH; c++) begin
                    r_prod[k][c] <= PROD_W'(C_COEF[k][c]) *
                                    PROD_W'($signed({1'b0, r_smp[c]}));
                end
            end
        end
    end

    // sum, sign and magnitude
    always_comb begin
        for (int k = 0; k < N_CH; k++) begin
            w_acc[k] = ACC_W'(r_prod[k][0]) + ACC_W'(r_prod[k][1]) + ACC_W'(r_prod[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int k = 0; k < N_CH; k++) begin
                r_neg2[k] <= w_acc[k][ACC_W-1];
                r_mag[k]  <= w_acc[k][ACC_W-1] ? MAG_W'(-w_acc[k]) : MAG_W'(w_acc[k]);
            end
        end
    end

    // restoring divider by 2*den, one quotient bit a stage
    always_comb begin
        for (int j = 0; j < N_DIV; j++) begin
            w_dvs[j] = NUM_W'({r_den, 1'b0}) << (N_DIV - 1 - j);
        end
    end

    always_ff @(posedge i_clk) begin
        // rounding numerator 2*mag*65535 + den
        if (w_adv[ST_NUM]) begin
            for (int k = 0; k < N_CH; k++) begin
                r_rem[0][k] <= NUM_W'({r_mag[k], 17'b0}) - NUM_W'({r_mag[k], 1'b0})
                               + NUM_W'(r_den);
                r_quo[0][k] <= '0;
                r_neg[0][k] <= r_neg2[k];
            end
        end
        for (int j = 0; j < N_DIV; j++) begin
            if (w_adv[ST_NUM+1+j]) begin
                for (int k = 0; k < N_CH; k++) begin
                    if (r_rem[j][k] >= w_dvs[j]) begin
                        r_rem[j+1][k] <= r_rem[j][k] - w_dvs[j];
                        r_quo[j+1][k] <= {r_quo[j][k][N_DIV-2:0], 1'b1};
                    end else begin
                        r_rem[j+1][k] <= r_rem[j][k];
                        r_quo[j+1][k] <= {r_quo[j][k][N_DIV-2:0], 1'b0};
                    end
                    r_neg[j+1][k] <= r_neg[j][k];
                end
            end
        end
    end

    // sign and saturation
    function automatic logic signed [OUT_W-1:0] chroma_of(input logic neg,
                                                          input logic [N_DIV-1:0] q);
        logic signed [OUT_W:0] v;
        logic signed [OUT_W-1:0] r;
        v = $signed({1'b0, q});
        if (neg) begin
            r = OUT_W'(-v);
        end else if (q[N_DIV-1]) begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

    always_comb begin
        n_out.luma        = r_neg[N_DIV][0] ? '0 : r_quo[N_DIV][0];
        n_out.chroma_blue = chroma_of(r_neg[N_DIV][1], r_quo[N_DIV][1]);
        n_out.chroma_red  = chroma_of(r_neg[N_DIV][2], r_quo[N_DIV][2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_OUT]) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_stall_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output word");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while the pipeline has a bubble");

    a_luma_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_NUM] |-> !r_neg[0][0])
        else $error("negative luma sum");
`endif

endmodule
